FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: design/wbgs_pkg.sv
`default_nettype none

package wbgs_pkg;

    // Field widths of the channels and registers
    localparam int POS_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CELL_W     = 8;
    localparam int CPM_W      = 32;
    localparam int SIZE_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [CPM_W-1:0]  CPM_RESET  = 32'd65536;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELLS_PER_METRE = 1'b0,
        REG_SIZE_LOG2       = 1'b1
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: design/wbgs_queue.sv
`default_nettype none

module wbgs_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  pop_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/wbgs_front.sv
`default_nettype none

module wbgs_front
    import wbgs_pkg::*;
#(
    parameter int GRID_SIDE_MAX = 256,
    parameter int FRAC_BITS     = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     opcode,
    input  wire logic signed [POS_W-1:0]  x_pos,
    input  wire logic signed [POS_W-1:0]  y_pos,
    input  wire logic [CELL_W-1:0]        cell_row,
    input  wire logic [CELL_W-1:0]        cell_col,
    input  wire logic signed [VAL_W-1:0]  cell_value,
    output logic                          q_push,
    output logic [1 + 2 + 4 * (((($clog2(GRID_SIDE_MAX + 1) - 2) > 0) ?
                  2 * ($clog2(GRID_SIDE_MAX + 1) - 2) : 1))
                  + 2 * FRAC_BITS + VAL_W - 1:0] q_data,
    input  wire logic                     q_ready
);

    localparam int IDX_W      = $clog2(GRID_SIDE_MAX + 1) - 1;
    localparam int HALF_W     = IDX_W - 1;
    localparam int BANK_AW    = (HALF_W > 0) ? 2 * HALF_W : 1;
    localparam int SIDE       = 1 << IDX_W;
    localparam int ADDR_TMP_W = 2 * IDX_W + 1;
    localparam int KEEP_W     = FRAC_BITS + IDX_W;
    localparam int MUL_W      = POS_W + CPM_W + 1;
    localparam logic [SIZE_W-1:0] K_MAX = SIZE_W'(IDX_W);

    // Configuration registers
    logic [CPM_W-1:0]  cpm_reg, cpm_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    // Input stage: scaled positions with the low fraction bits dropped
    logic              f1_valid_reg, f1_valid_next;
    op_t               f1_op_reg;
    logic [KEEP_W-1:0] f1_px_reg, f1_py_reg;
    logic [CELL_W-1:0] f1_row_reg, f1_col_reg;
    logic [VAL_W-1:0]  f1_value_reg;

    logic signed [MUL_W-1:0] px_full, py_full;
    logic                    f1_load;
    logic                    need_push;
    logic                    wr_ok;

    logic [SIZE_W-1:0]    k_eff;
    logic [IDX_W-1:0]     imask;
    logic [IDX_W-1:0]     i0, i1, j0, j1;
    logic [IDX_W-1:0]     row_w, col_w;
    logic [FRAC_BITS-1:0] fx, fy;
    logic [1:0]           sel;
    logic [BANK_AW-1:0]   addr [4];

    function automatic logic [BANK_AW-1:0] bank_addr(
        input logic [IDX_W-1:0] r,
        input logic [IDX_W-1:0] c
    );
        logic [ADDR_TMP_W-1:0] rr;
        logic [ADDR_TMP_W-1:0] cc;
        rr = ADDR_TMP_W'(r) >> 1;
        cc = ADDR_TMP_W'(c) >> 1;
        return BANK_AW'((rr << HALF_W) | cc);
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cpm_next  = cpm_reg;
        size_next = size_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CELLS_PER_METRE: cpm_next  = cfg_data[CPM_W-1:0];
                REG_SIZE_LOG2:       size_next = cfg_data[SIZE_W-1:0];
                default:             cpm_next  = cpm_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpm_reg  <= CPM_RESET;
            size_reg <= SIZE_RESET;
        end
        else
        begin
            cpm_reg  <= cpm_next;
            size_reg <= size_next;
        end
    end

    // Scale both positions into grid units at the input
    assign px_full = $signed(x_pos) * $signed({1'b0, cpm_reg});
    assign py_full = $signed(y_pos) * $signed({1'b0, cpm_reg});

    assign in_stall      = f1_valid_reg && need_push && !q_ready;
    assign f1_load       = in_valid && !in_stall;
    assign f1_valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_load)
        begin
            f1_op_reg    <= op_t'(opcode);
            f1_px_reg    <= px_full[FRAC_BITS +: KEEP_W];
            f1_py_reg    <= py_full[FRAC_BITS +: KEEP_W];
            f1_row_reg   <= cell_row;
            f1_col_reg   <= cell_col;
            f1_value_reg <= cell_value;
        end
    end

    // Classify: wrap the indices, pick the bank of each neighbor
    always_comb
    begin
        if (size_reg == '0)
        begin
            k_eff = SIZE_W'(1);
        end
        else if (size_reg > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = size_reg;
        end
        imask = IDX_W'(({{IDX_W{1'b0}}, 1'b1} << k_eff) - 1'b1);

        i0 = f1_px_reg[FRAC_BITS +: IDX_W] & imask;
        j0 = f1_py_reg[FRAC_BITS +: IDX_W] & imask;
        i1 = IDX_W'(i0 + 1'b1) & imask;
        j1 = IDX_W'(j0 + 1'b1) & imask;
        fx = f1_px_reg[FRAC_BITS-1:0];
        fy = f1_py_reg[FRAC_BITS-1:0];

        row_w = IDX_W'(f1_row_reg);
        col_w = IDX_W'(f1_col_reg);
        wr_ok = (32'(f1_row_reg) < 32'(SIDE)) && (32'(f1_col_reg) < 32'(SIDE));

        if (f1_op_reg == OP_SAMPLE)
        begin
            sel = {i0[0], j0[0]};
            for (int b = 0; b < 4; b++)
            begin
                addr[b] = bank_addr((i0[0] == 1'(b >> 1)) ? i0 : i1,
                                    (j0[0] == 1'(b))      ? j0 : j1);
            end
        end
        else
        begin
            sel = {row_w[0], col_w[0]};
            for (int b = 0; b < 4; b++)
            begin
                addr[b] = bank_addr(row_w, col_w);
            end
        end
    end

    // Drop writes that fall outside the stored grid
    assign need_push = (f1_op_reg == OP_SAMPLE) || wr_ok;
    assign q_push    = f1_valid_reg && need_push && q_ready;
    assign q_data    = {f1_op_reg, sel, addr[3], addr[2], addr[1], addr[0],
                        fx, fy, f1_value_reg};

endmodule

`default_nettype wire

FILE: design/wbgs_back.sv
`default_nettype none

module wbgs_back
    import wbgs_pkg::*;
#(
    parameter int GRID_SIDE_MAX = 256,
    parameter int FRAC_BITS     = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire logic [1 + 2 + 4 * (((($clog2(GRID_SIDE_MAX + 1) - 2) > 0) ?
                       2 * ($clog2(GRID_SIDE_MAX + 1) - 2) : 1))
                       + 2 * FRAC_BITS + VAL_W - 1:0] q_data,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [VAL_W-1:0]      sample_value
);

    localparam int IDX_W      = $clog2(GRID_SIDE_MAX + 1) - 1;
    localparam int HALF_W     = IDX_W - 1;
    localparam int BANK_AW    = (HALF_W > 0) ? 2 * HALF_W : 1;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int FY_LO      = VAL_W;
    localparam int FX_LO      = VAL_W + FRAC_BITS;
    localparam int ADDR_LO    = VAL_W + 2 * FRAC_BITS;
    localparam int SEL_LO     = ADDR_LO + 4 * BANK_AW;
    localparam int OP_BIT     = SEL_LO + 2;
    localparam int AXW        = VAL_W + FRAC_BITS;
    localparam int SLW        = 2 * FRAC_BITS;
    localparam int SUMW       = VAL_W + 2 * FRAC_BITS + 1;
    localparam logic [FRAC_BITS:0] ONE        = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [SUMW-1:0]    ROUND_HALF = SUMW'(1) << (2 * FRAC_BITS - 1);
    localparam logic [VAL_W-1:0]   SIGN_FLIP  = VAL_W'(1) << (VAL_W - 1);

    // Queue head fields
    op_t                  hd_op;
    logic [1:0]           hd_sel;
    logic [BANK_AW-1:0]   hd_addr [4];
    logic [FRAC_BITS-1:0] hd_fx, hd_fy;
    logic [VAL_W-1:0]     hd_wdata;

    logic adv;

    // Stage 1: bank read data
    logic                 b1_valid_reg, b1_valid_next;
    logic [1:0]           b1_sel_reg;
    logic [FRAC_BITS-1:0] b1_fx_reg, b1_fy_reg;
    logic [VAL_W-1:0]     rd_reg [4];

    // Stage 2: blend along the first index
    logic                 b2_valid_reg, b2_valid_next;
    logic [AXW-1:0]       b2_ax0_reg, b2_ax1_reg;
    logic [FRAC_BITS-1:0] b2_fy_reg;

    // Stage 3: blend along the second index, split in high and low parts
    logic                 b3_valid_reg, b3_valid_next;
    logic [AXW-1:0]       b3_sh_reg;
    logic [SLW-1:0]       b3_sl_reg;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]     sample_value_reg;

    logic [VAL_W-1:0]     t00, t01, t10, t11;
    logic [VAL_W-1:0]     u00, u01, u10, u11;
    logic [FRAC_BITS:0]   wx0, wy0;
    logic [AXW-1:0]       ax0, ax1, sh;
    logic [SLW-1:0]       sl;
    logic [SUMW-1:0]      sum;

    assign hd_op    = op_t'(q_data[OP_BIT]);
    assign hd_sel   = q_data[SEL_LO +: 2];
    assign hd_fx    = q_data[FX_LO +: FRAC_BITS];
    assign hd_fy    = q_data[FY_LO +: FRAC_BITS];
    assign hd_wdata = q_data[VAL_W-1:0];

    // The whole back end holds while a finished result is stalled
    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = adv && q_valid;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [VAL_W-1:0] mem [BANK_DEPTH];
        logic             wr_en;

        assign hd_addr[b] = q_data[ADDR_LO + b * BANK_AW +: BANK_AW];
        assign wr_en      = q_pop && (hd_op == OP_WRITE) && (hd_sel == 2'(b));

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[hd_addr[b]] <= hd_wdata;
            end
            if (adv)
            begin
                rd_reg[b] <= mem[hd_addr[b]];
            end
        end
    end

    assign b1_valid_next  = adv ? (q_valid && (hd_op == OP_SAMPLE)) : b1_valid_reg;
    assign b2_valid_next  = adv ? b1_valid_reg : b2_valid_reg;
    assign b3_valid_next  = adv ? b2_valid_reg : b3_valid_reg;
    assign out_valid_next = adv ? b3_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            b2_valid_reg  <= b2_valid_next;
            b3_valid_reg  <= b3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Undo the bank order: swap by row parity, then by column parity
    always_comb
    begin
        t00 = b1_sel_reg[1] ? rd_reg[2] : rd_reg[0];
        t01 = b1_sel_reg[1] ? rd_reg[3] : rd_reg[1];
        t10 = b1_sel_reg[1] ? rd_reg[0] : rd_reg[2];
        t11 = b1_sel_reg[1] ? rd_reg[1] : rd_reg[3];
        u00 = (b1_sel_reg[0] ? t01 : t00) ^ SIGN_FLIP;
        u01 = (b1_sel_reg[0] ? t00 : t01) ^ SIGN_FLIP;
        u10 = (b1_sel_reg[0] ? t11 : t10) ^ SIGN_FLIP;
        u11 = (b1_sel_reg[0] ? t10 : t11) ^ SIGN_FLIP;
        wx0 = ONE - {1'b0, b1_fx_reg};
        ax0 = AXW'(u00) * AXW'(wx0) + AXW'(u10) * AXW'(b1_fx_reg);
        ax1 = AXW'(u01) * AXW'(wx0) + AXW'(u11) * AXW'(b1_fx_reg);
    end

    always_comb
    begin
        wy0 = ONE - {1'b0, b2_fy_reg};
        sh  = AXW'(b2_ax0_reg[AXW-1:FRAC_BITS]) * AXW'(wy0)
            + AXW'(b2_ax1_reg[AXW-1:FRAC_BITS]) * AXW'(b2_fy_reg);
        sl  = SLW'(b2_ax0_reg[FRAC_BITS-1:0]) * SLW'(wy0)
            + SLW'(b2_ax1_reg[FRAC_BITS-1:0]) * SLW'(b2_fy_reg);
    end

    // Round to nearest, ties up
    assign sum = (SUMW'(b3_sh_reg) << FRAC_BITS) + SUMW'(b3_sl_reg) + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_sel_reg <= hd_sel;
            b1_fx_reg  <= hd_fx;
            b1_fy_reg  <= hd_fy;
            b2_ax0_reg <= ax0;
            b2_ax1_reg <= ax1;
            b2_fy_reg  <= b1_fy_reg;
            b3_sh_reg  <= sh;
            b3_sl_reg  <= sl;
        end
        if (adv && b3_valid_reg)
        begin
            sample_value_reg <= sum[2 * FRAC_BITS +: VAL_W] ^ SIGN_FLIP;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_value_reg;

endmodule

`default_nettype wire

FILE: design/wrapped_bilinear_grid_sampler.sv
// Wrapped bilinear grid sampler.
// Input channel (in_valid / in_stall) carries one item per transfer: opcode 0
// stores cell_value at (cell_row, cell_col); opcode 1 samples at (x_pos, y_pos).
// A sample yields one sample_value transfer on the output channel
// (out_valid / out_stall); a write yields none. Config writes go through
// cfg_valid / cfg_ready (always ready) with cfg_index selecting the register.
// A sample passes the input stage, queue, bank read, blend stages and output
// register. Throughput: one item per cycle unless stalled, set by the four
// parity banks of the grid memory, which read a sample's four neighbors at once.
// Reset clears the pipeline and loads cells_per_metre = 1.0 and size_log2 = 8.
// The grid is not cleared: cells read before being written return garbage.
// When out_stall holds the output, the back end freezes; the front keeps
// taking items until the 4-entry queue and its input stage are full, then
// raises in_stall.
`default_nettype none

module wrapped_bilinear_grid_sampler
    import wbgs_pkg::*;
#(
    parameter int GRID_SIDE_MAX = 256,
    parameter int FRAC_BITS     = 16,
    parameter int QUEUE_DEPTH   = 4
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    opcode,
    input  wire logic signed [POS_W-1:0] x_pos,
    input  wire logic signed [POS_W-1:0] y_pos,
    input  wire logic [CELL_W-1:0]       cell_row,
    input  wire logic [CELL_W-1:0]       cell_col,
    input  wire logic signed [VAL_W-1:0] cell_value,
    // output channel
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [VAL_W-1:0]      sample_value
);

    // Queue entry: op, bank select, four bank addresses, two weights, data
    localparam int IDX_W   = $clog2(GRID_SIDE_MAX + 1) - 1;
    localparam int HALF_W  = IDX_W - 1;
    localparam int BANK_AW = (HALF_W > 0) ? 2 * HALF_W : 1;
    localparam int ENTRY_W = 1 + 2 + 4 * BANK_AW + 2 * FRAC_BITS + VAL_W;

    logic               q_push;
    logic               q_ready;
    logic [ENTRY_W-1:0] q_wdata;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_rdata;

    // Front: config, position scaling, index wrap and bank classification
    wbgs_front
    #(
        .GRID_SIDE_MAX (GRID_SIDE_MAX),
        .FRAC_BITS     (FRAC_BITS)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .cell_value (cell_value),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .q_ready    (q_ready)
    );

    // Decouple the front from the memory and blend pipeline
    wbgs_queue
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_wdata),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_rdata),
        .pop_valid  (q_valid)
    );

    // Back: banked grid memory, two blend stages, rounding, output register
    wbgs_back
    #(
        .GRID_SIDE_MAX (GRID_SIDE_MAX),
        .FRAC_BITS     (FRAC_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value)
    );

endmodule

`default_nettype wire

FILE: design/wbgs_checker.sv
`default_nettype none

`include "assert_macros.svh"

module wbgs_checker
    import wbgs_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [VAL_W-1:0] sample_value
);

    // A result stalled by the receiver stays offered
    `ASSERT_PROP(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "stalled result dropped")

    // A stalled result keeps its value
    `ASSERT_PROP(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(sample_value), "stalled result changed")

    // Input stall only while an item taken earlier is still held
    `ASSERT_PROP(a_stall_has_item, clk, rst_n, in_stall |-> $past(in_valid && !in_stall) || $past(in_stall), "in_stall without a held item")

    // No result right out of reset
    `ASSERT_NEVER(a_reset_quiet, clk, rst_n, $rose(rst_n) && out_valid, "result valid at reset release")

endmodule

bind wrapped_bilinear_grid_sampler wbgs_checker u_wbgs_checker (.*);

`default_nettype wire

FILE: tb/tb_wrapped_bilinear_grid_sampler.sv
`default_nettype none

module tb_wrapped_bilinear_grid_sampler;
    import wbgs_pkg::*;

    // Cycles to let the pipeline settle after the last expected sample has come.
    // A sample gets an answer; writes give no result at all.
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 48;
    localparam int GAP_PERCENT   = 31;

    // One input item as the block sees it.
    typedef struct {
        op_t                 op;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic [7:0]          row;
        logic [7:0]          col;
        logic signed [31:0]  value;
    } grid_item_t;

    // Keeps a shadow grid and the two registers, predicts every sample and
    // holds the predicted values until the block delivers them.
    class sample_board;
        logic [CPM_W-1:0]  cpm;
        logic [SIZE_W-1:0] size_reg;
        logic [31:0]       cells [65536];
        bit                loaded [65536];
        logic [31:0]       predicted_samples [$];
        int                errors;

        function new();
            cpm      = CPM_RESET;
            size_reg = SIZE_RESET;
            errors   = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_CELLS_PER_METRE)
                cpm = data;
            else
                size_reg = data[SIZE_W-1:0];
        endfunction

        // Clamp the side exponent to 1 .. 8 (a 256 wide grid).
        function int grid_log2();
            int k;
            k = int'(size_reg);
            if (k < 1)
                k = 1;
            if (k > 8)
                k = 8;
            return k;
        endfunction

        // Scale one position into grid units; give the two wrapped indexes
        // and the 16-bit fraction between them.
        function void axis(logic signed [31:0] pos, output logic [7:0] lo,
                           output logic [7:0] hi, output logic [15:0] frac);
            longint     p;
            logic [7:0] mask;
            p    = longint'(pos) * longint'({32'h0, cpm});
            mask = 8'((9'd1 << grid_log2()) - 9'd1);
            lo   = p[39:32] & mask;
            hi   = (lo + 8'd1) & mask;
            frac = p[31:16];
        endfunction

        function logic [31:0] blend(logic signed [31:0] x, logic signed [31:0] y);
            logic [7:0]  i0, i1, j0, j1;
            logic [15:0] fx, fy;
            logic [16:0] wx0, wy0;
            logic [33:0] w [4];
            logic [7:0]  ri [4];
            logic [7:0]  ci [4];
            logic [65:0] acc;
            axis(x, i0, i1, fx);
            axis(y, j0, j1, fy);
            wx0 = 17'h1_0000 - 17'(fx);
            wy0 = 17'h1_0000 - 17'(fy);
            w[0] = 34'(wx0) * 34'(wy0); ri[0] = i0; ci[0] = j0;
            w[1] = 34'(fx)  * 34'(wy0); ri[1] = i1; ci[1] = j0;
            w[2] = 34'(wx0) * 34'(fy);  ri[2] = i0; ci[2] = j1;
            w[3] = 34'(fx)  * 34'(fy);  ri[3] = i1; ci[3] = j1;
            // Sum in offset binary, then round half up by adding half an LSB.
            acc = 66'd1 << 31;
            for (int t = 0; t < 4; t++)
                acc = acc + 66'(cells[{ri[t], ci[t]}] ^ 32'h8000_0000) * 66'(w[t]);
            return acc[63:32] ^ 32'h8000_0000;
        endfunction

        function void note_item(grid_item_t it);
            if (it.op == OP_WRITE) begin
                cells[{it.row, it.col}]  = it.value;
                loaded[{it.row, it.col}] = 1'b1;
            end
            else begin
                predicted_samples.push_back(blend(it.x, it.y));
            end
        endfunction

        function void check_sample(logic [31:0] got);
            logic [31:0] want;
            if (predicted_samples.size() == 0) begin
                $display("%0t: sample_value %h with none expected", $time, got);
                errors++;
            end
            else begin
                want = predicted_samples.pop_front();
                if (want !== got) begin
                    $display("%0t: sample_value expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return predicted_samples.size();
        endfunction
    endclass

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index    = REG_CELLS_PER_METRE;
    logic [CFG_DATA_W-1:0]   cfg_data     = '0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic                    opcode       = OP_WRITE;
    logic signed [POS_W-1:0] x_pos        = '0;
    logic signed [POS_W-1:0] y_pos        = '0;
    logic [CELL_W-1:0]       cell_row     = '0;
    logic [CELL_W-1:0]       cell_col     = '0;
    logic signed [VAL_W-1:0] cell_value   = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic signed [VAL_W-1:0] sample_value;

    // Random gaps on both sides while set; clear it for a stretch at full rate.
    bit gaps_on  = 1'b1;
    // Ask the receiver for one long hold-off.
    bit hold_req = 1'b0;

    sample_board board;

    wrapped_bilinear_grid_sampler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .cell_value   (cell_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check every output transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_sample(sample_value);
    end

    // Receiver: drive stall at the falling edge. On request, hold off for a
    // long stretch so the block backs up and stalls its input.
    initial
    begin : receiver
        int left;
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                for (left = HOLD_CYCLES; left > 0; left--)
                    @(negedge clk);
            end
            out_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PERCENT);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #3_000_000;
        $display("wrapped_bilinear_grid_sampler verification failed");
        $finish;
    end

    // Offer one item and hold it until the transfer. Call at a falling edge;
    // returns at the falling edge after the transfer with valid still high, so
    // the caller either offers the next item right away or drops valid.
    task automatic send_item(grid_item_t it);
        while (gaps_on && ($urandom_range(0, 99) < GAP_PERCENT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= it.op;
        x_pos      <= it.x;
        y_pos      <= it.y;
        cell_row   <= it.row;
        cell_col   <= it.col;
        cell_value <= it.value;
        do
            @(posedge clk);
        while (in_stall);
        board.note_item(it);
        @(negedge clk);
    endtask

    task automatic put_write(logic [7:0] row, logic [7:0] col, logic signed [31:0] value);
        grid_item_t it;
        it.op    = OP_WRITE;
        it.x     = $urandom();
        it.y     = $urandom();
        it.row   = row;
        it.col   = col;
        it.value = value;
        send_item(it);
    endtask

    // Load a cell with a random value if it has never been written.
    task automatic cover_cell(logic [7:0] row, logic [7:0] col);
        if (!board.loaded[{row, col}])
            put_write(row, col, $urandom());
    endtask

    // Sample at a position; first fill any of the four neighbors that
    // were never written, so no undefined cell is ever read.
    task automatic put_sample(logic signed [31:0] x, logic signed [31:0] y);
        grid_item_t  it;
        logic [7:0]  i0, i1, j0, j1;
        logic [15:0] fx, fy;
        board.axis(x, i0, i1, fx);
        board.axis(y, j0, j1, fy);
        cover_cell(i0, j0);
        cover_cell(i1, j0);
        cover_cell(i0, j1);
        cover_cell(i1, j1);
        it.op    = OP_SAMPLE;
        it.x     = x;
        it.y     = y;
        it.row   = 8'($urandom());
        it.col   = 8'($urandom());
        it.value = $urandom();
        send_item(it);
    endtask

    // Drop valid, wait for every predicted sample, then let the pipe settle.
    task automatic drain();
        int spins;
        in_valid <= 1'b0;
        spins = 0;
        while (board.outstanding() != 0 && spins < DRAIN_LIMIT)
        begin
            @(negedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers back to back, valid held high between transfers.
    // Call only with the block idle. Upper bits of the size write are junk.
    task automatic apply_setting(logic [CPM_W-1:0] cpm, logic [SIZE_W-1:0] size);
        logic [CFG_DATA_W-1:0] size_word;
        size_word = {(CFG_DATA_W - SIZE_W)'($urandom()), size};
        cfg_valid <= 1'b1;
        cfg_index <= REG_CELLS_PER_METRE;
        cfg_data  <= cpm;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(REG_CELLS_PER_METRE, cpm);
        @(negedge clk);
        cfg_index <= REG_SIZE_LOG2;
        cfg_data  <= size_word;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(REG_SIZE_LOG2, size_word);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Position within a few hundred metres of the origin, either sign.
    function automatic logic signed [31:0] near_pos();
        return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    endfunction

    // One random item: writes anywhere, writes inside the active tile,
    // samples anywhere in the 32-bit range and samples near the origin.
    task automatic random_item();
        int pick;
        int side;
        side = 1 << board.grid_log2();
        pick = $urandom_range(0, 99);
        if (pick < 20)
            put_write(8'($urandom()), 8'($urandom()), $urandom());
        else if (pick < 35)
            put_write(8'($urandom_range(0, side - 1)), 8'($urandom_range(0, side - 1)),
                      $urandom());
        else if (pick < 50)
            put_sample($urandom(), $urandom());
        else
            put_sample(near_pos(), near_pos());
    endtask

    initial
    begin : stimulus
        logic [CPM_W-1:0]  cpm_v;
        logic [SIZE_W-1:0] size_v;
        int                left;
        board = new();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset setting: one cell per metre, 256 wide.
        // Extreme cell values next to each other, so blends span the full range.
        put_write(8'd0,   8'd0,   32'sh7FFF_FFFF);
        put_write(8'd1,   8'd0,   32'sh8000_0000);
        put_write(8'd0,   8'd1,   32'sh0000_0000);
        put_write(8'd1,   8'd1,   32'shFFFF_FFFF);
        put_write(8'd255, 8'd255, 32'sh7FFF_FFFF);
        put_write(8'd255, 8'd0,   32'sh8000_0000);
        put_write(8'd0,   8'd255, 32'sh1234_5678);
        put_write(8'd2,   8'd0,   32'shFFFF_FFFF);
        put_write(8'd3,   8'd0,   32'sh0000_0000);
        put_sample(32'sh0000_0000, 32'sh0000_0000);
        put_sample(32'sh0000_8000, 32'sh0000_8000);
        // Exact half way between -1 LSB and 0: the tie rounds up to 0.
        put_sample(32'sh0002_8000, 32'sh0000_0000);
        // Negative positions wrap to the far edge of the tile.
        put_sample(32'shFFFF_FFFF, 32'shFFFF_8000);
        put_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
        // Index 255 blends with index 0 across the seam.
        put_sample(32'sh00FF_8000, 32'sh00FF_C000);
        drain();

        // Largest scale with an oversized size code (saturates to 256).
        apply_setting(32'hFFFF_FFFF, 4'd15);
        put_sample(32'sh0000_0001, 32'sh7FFF_FFFF);
        put_sample(32'sh8000_0000, 32'shFFFF_FFFF);
        drain();

        // Zero scale with size code zero (acts as a 2 wide grid).
        apply_setting(32'h0000_0000, 4'd0);
        put_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
        put_sample(32'sh1234_5678, 32'shDEAD_BEEF);
        drain();

        // Random phases, each under its own setting. The drain between phases
        // doubles as a full pause of the sender until every sample has come.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin cpm_v = 32'h0001_0000; size_v = 4'd2;  end
                1: begin cpm_v = 32'h0004_0000; size_v = 4'd3;  end
                2: begin cpm_v = 32'hFFFF_FFFF; size_v = 4'd15; end
                3: begin cpm_v = 32'h0000_0000; size_v = 4'd0;  end
                4: begin cpm_v = $urandom();    size_v = 4'd1;  end
                5: begin cpm_v = 32'h0000_8000; size_v = 4'd8;  end
                6: begin cpm_v = $urandom_range(0, 32'h0010_0000); size_v = 4'($urandom()); end
                default: begin cpm_v = 32'h0010_0000; size_v = 4'd4; end
            endcase
            apply_setting(cpm_v, size_v);
            // Run one phase flat out, with no gaps on either side.
            gaps_on = (ph != 1);
            // Stall the output for a long stretch while items keep coming.
            if (ph == 5)
                hold_req = 1'b1;
            for (left = PHASE_ITEMS; left > 0; left--)
                random_item();
            drain();
        end

        if (board.outstanding() != 0) begin
            $display("%0t: %0d expected sample_value transfers never arrived",
                     $time, board.outstanding());
            board.errors += board.outstanding();
        end
        if (board.errors == 0)
            $display("wrapped_bilinear_grid_sampler verification clean");
        else
            $display("wrapped_bilinear_grid_sampler verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/wbgs_pkg.sv
design/wbgs_queue.sv
design/wbgs_front.sv
design/wbgs_back.sv
design/wrapped_bilinear_grid_sampler.sv
design/wbgs_checker.sv
tb/tb_wrapped_bilinear_grid_sampler.sv
